// ===== design/sdb_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdb_pkg
// Shared types and constants for the sliding DCT dominant-bin tracker.
// ---------------------------------------------------------------------------
package sdb_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FILL_W   = 7;
    localparam int BIN_W    = 6;
    localparam int POWER_W  = 43;
    localparam int TOTAL_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam int MIN_WIN  = 8;
    localparam int MIN_NEED = 4;

    localparam logic [FILL_W-1:0] RST_WINDOW_LENGTH = 7'd64;
    localparam logic [FILL_W-1:0] RST_MIN_FILL      = 7'd16;
    localparam logic [BIN_W-1:0]  RST_MAX_BIN       = 6'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FILL      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BIN       = 2'd2;

    // CORDIC: 24 rotations, angles in binary turns (2^32 per turn)
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 34;
    localparam int CNT_W        = 5;
    localparam logic signed [CORDIC_W-1:0] CORDIC_INV_GAIN = 34'sd652032874;
    localparam int DIV_STEPS    = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_BIN,
        S_RD,
        S_DIV,
        S_CINIT,
        S_COR,
        S_MUL,
        S_ACC,
        S_RND,
        S_SQ,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;     // write sample, update pointer/fill/total
        logic cfg_wr;     // config write, clears history for a listed index
        logic bin_init;   // start bin sweep
        logic term_init;  // start sample sweep for current bin
        logic rd;         // ring read + divider load
        logic div_step;
        logic cor_init;
        logic cor_step;
        logic mul;
        logic acc;        // accumulate and advance to next sample
        logic rnd;
        logic sq;
        logic cmp;        // compare, commit on last bin, else next bin
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic ran;
        logic has_bins;
        logic div_last;
        logic cor_last;
        logic last_term;
        logic last_bin;
        logic out_busy;
    } t_stat;

    function automatic logic [29:0] atan_turn(input logic [CNT_W-1:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/sdb_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdb_ctrl
// Sequencer: walks bins, samples, divider and CORDIC steps of the datapath.
// ---------------------------------------------------------------------------
module sdb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_cfg_valid,
    input  logic          i_ready,
    input  sdb_pkg::t_stat i_stat,
    output logic          o_ready,
    output logic          o_cfg_ready,
    output sdb_pkg::t_cmd o_cmd
);

    sdb_pkg::t_state r_state;
    sdb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sdb_pkg::S_IDLE: begin
                if (!i_cfg_valid && i_valid) n_state = sdb_pkg::S_CHECK;
            end
            sdb_pkg::S_CHECK: begin
                n_state = (i_stat.ran && i_stat.has_bins) ? sdb_pkg::S_BIN : sdb_pkg::S_DONE;
            end
            sdb_pkg::S_BIN:   n_state = sdb_pkg::S_RD;
            sdb_pkg::S_RD:    n_state = sdb_pkg::S_DIV;
            sdb_pkg::S_DIV: begin
                if (i_stat.div_last) n_state = sdb_pkg::S_CINIT;
            end
            sdb_pkg::S_CINIT: n_state = sdb_pkg::S_COR;
            sdb_pkg::S_COR: begin
                if (i_stat.cor_last) n_state = sdb_pkg::S_MUL;
            end
            sdb_pkg::S_MUL:   n_state = sdb_pkg::S_ACC;
            sdb_pkg::S_ACC: begin
                n_state = i_stat.last_term ? sdb_pkg::S_RND : sdb_pkg::S_RD;
            end
            sdb_pkg::S_RND:   n_state = sdb_pkg::S_SQ;
            sdb_pkg::S_SQ:    n_state = sdb_pkg::S_CMP;
            sdb_pkg::S_CMP: begin
                n_state = i_stat.last_bin ? sdb_pkg::S_DONE : sdb_pkg::S_BIN;
            end
            sdb_pkg::S_DONE: begin
                if (!i_stat.out_busy || i_ready) n_state = sdb_pkg::S_IDLE;
            end
            default: n_state = sdb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_ready     = 1'b0;
        o_cfg_ready = 1'b0;
        case (r_state)
            sdb_pkg::S_IDLE: begin
                o_cfg_ready = 1'b1;
                o_ready     = !i_cfg_valid;
                o_cmd.cfg_wr = i_cfg_valid;
                o_cmd.accept = !i_cfg_valid && i_valid;
            end
            sdb_pkg::S_CHECK: o_cmd.bin_init  = i_stat.ran && i_stat.has_bins;
            sdb_pkg::S_BIN:   o_cmd.term_init = 1'b1;
            sdb_pkg::S_RD:    o_cmd.rd        = 1'b1;
            sdb_pkg::S_DIV:   o_cmd.div_step  = 1'b1;
            sdb_pkg::S_CINIT: o_cmd.cor_init  = 1'b1;
            sdb_pkg::S_COR:   o_cmd.cor_step  = 1'b1;
            sdb_pkg::S_MUL:   o_cmd.mul       = 1'b1;
            sdb_pkg::S_ACC:   o_cmd.acc       = 1'b1;
            sdb_pkg::S_RND:   o_cmd.rnd       = 1'b1;
            sdb_pkg::S_SQ:    o_cmd.sq        = 1'b1;
            sdb_pkg::S_CMP:   o_cmd.cmp       = 1'b1;
            sdb_pkg::S_DONE:  o_cmd.load_out  = !i_stat.out_busy || i_ready;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== design/sdb_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdb_dp
// Datapath: sample ring, phase divider, CORDIC cosine, MAC, peak search.
// ---------------------------------------------------------------------------
module sdb_dp #(
    parameter int MAX_WINDOW = 64,
    parameter int K_MAX      = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sdb_pkg::t_cmd                        i_cmd,
    output sdb_pkg::t_stat                       o_stat,
    input  logic                                 i_ready,
    input  logic signed [sdb_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [sdb_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [sdb_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                 o_valid,
    output logic                                 o_analysed,
    output logic [sdb_pkg::BIN_W-1:0]            o_dominant_bin,
    output logic [sdb_pkg::POWER_W-1:0]          o_peak_power,
    output logic [sdb_pkg::FILL_W-1:0]           o_window_fill,
    output logic                                 o_bin_changed,
    output logic [sdb_pkg::BIN_W-1:0]            o_previous_bin,
    output logic [sdb_pkg::TOTAL_W-1:0]          o_total_samples
);

    localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW   = ((AW > sdb_pkg::FILL_W) ? AW : sdb_pkg::FILL_W) + 1;
    localparam int KCAP = (K_MAX < 63) ? K_MAX : 63;
    localparam int FW   = sdb_pkg::FILL_W;
    localparam int BW   = sdb_pkg::BIN_W;
    localparam int XW   = sdb_pkg::CORDIC_W;

    // config
    logic [FW-1:0] r_wl, r_mf;
    logic [BW-1:0] r_mb;

    // history
    logic [sdb_pkg::SAMPLE_W-1:0] r_ring [MAX_WINDOW];
    logic [CW-1:0]                r_wp;
    logic [FW-1:0]                r_fill;
    logic [BW-1:0]                r_best_bin, r_last_bin;
    logic [sdb_pkg::POWER_W-1:0]  r_best_pow;
    logic [sdb_pkg::TOTAL_W-1:0]  r_total;

    // sweep
    logic [BW-1:0]                r_k, r_win_k;
    logic [sdb_pkg::POWER_W-1:0]  r_win_p;
    logic                         r_found;
    logic [FW-1:0]                r_i;
    logic [CW-1:0]                r_idx;
    logic [8:0]                   r_ph;
    logic signed [sdb_pkg::SAMPLE_W-1:0] r_rd;

    // divider
    logic [9:0]                   r_rem;
    logic [31:0]                  r_q;
    logic [sdb_pkg::CNT_W-1:0]    r_dcnt;

    // cordic
    logic signed [XW-1:0]         r_x, r_y, r_z;
    logic                         r_neg;
    logic [sdb_pkg::CNT_W-1:0]    r_ccnt;

    // mac
    logic signed [33:0]           r_prod;
    logic signed [40:0]           r_acc;
    logic signed [25:0]           r_coef;
    logic [sdb_pkg::POWER_W-1:0]  r_pow;

    // output register
    logic                         r_o_valid;

    // ---------------- combinational helpers ----------------
    logic [CW-1:0] w_win, w_fill, w_wp_eff, w_wp_inc;
    logic [FW-1:0] w_need, w_lim;
    logic [9:0]    w_ph_sum, w_dtry;
    logic [8:0]    w_div;
    logic [31:0]   w_turn_fold;
    logic signed [XW-1:0] w_dx, w_dy, w_at, w_xr;
    logic signed [18:0]   w_cr;
    logic signed [17:0]   w_cos;
    logic signed [33:0]   w_ma, w_mb;
    logic signed [40:0]   w_ar;
    logic signed [51:0]   w_sq;
    logic [BW-1:0]        w_nk;
    logic [sdb_pkg::POWER_W-1:0] w_np;

    always_comb begin
        if (int'(r_wl) < sdb_pkg::MIN_WIN) begin
            w_win = CW'(sdb_pkg::MIN_WIN);
        end else if (int'(r_wl) > MAX_WINDOW) begin
            w_win = CW'(MAX_WINDOW);
        end else begin
            w_win = CW'(r_wl);
        end
        w_fill   = CW'(r_fill);
        w_wp_eff = (r_wp >= w_win) ? '0 : r_wp;
        w_wp_inc = (w_wp_eff + 1'b1 == w_win) ? '0 : w_wp_eff + 1'b1;

        w_need = (int'(r_mf) < sdb_pkg::MIN_NEED) ? FW'(sdb_pkg::MIN_NEED) : r_mf;
        w_lim  = FW'(r_mb);
        if (KCAP < int'(w_lim)) w_lim = FW'(KCAP);
        if ((r_fill >> 1) < w_lim) w_lim = r_fill >> 1;

        // phase step: (2i+1)k mod 4N, one conditional subtract
        w_div    = {r_fill, 2'b00};
        w_ph_sum = {1'b0, r_ph} + {3'b000, r_k, 1'b0};
        if (w_ph_sum >= {1'b0, w_div}) w_ph_sum = w_ph_sum - {1'b0, w_div};

        w_dtry = {r_rem[8:0], 1'b0};

        w_turn_fold = r_q + 32'h8000_0000;

        w_dx = r_y >>> r_ccnt;
        w_dy = r_x >>> r_ccnt;
        w_at = XW'(sdb_pkg::atan_turn(r_ccnt));

        // cosine: round x to Q1.15, apply fold sign, clamp
        w_xr = r_x + XW'(16384);
        w_cr = w_xr[XW-1:15];
        if (r_neg) w_cr = -w_cr;
        if (w_cr > 19'sd32768) begin
            w_cos = 18'sd32768;
        end else if (w_cr < -19'sd32768) begin
            w_cos = -18'sd32768;
        end else begin
            w_cos = w_cr[17:0];
        end
        w_ma = {{18{r_rd[15]}}, r_rd};
        w_mb = {{16{w_cos[17]}}, w_cos};

        w_ar = r_acc + 41'sd16384;
        w_sq = {{26{r_coef[25]}}, r_coef} * {{26{r_coef[25]}}, r_coef};

        if (!r_found || r_pow > r_win_p) begin
            w_nk = r_k;
            w_np = r_pow;
        end else begin
            w_nk = r_win_k;
            w_np = r_win_p;
        end
    end

    assign o_stat.ran       = r_fill >= w_need;
    assign o_stat.has_bins  = w_lim != '0;
    assign o_stat.div_last  = r_dcnt == sdb_pkg::CNT_W'(sdb_pkg::DIV_STEPS - 1);
    assign o_stat.cor_last  = r_ccnt == sdb_pkg::CNT_W'(sdb_pkg::CORDIC_STEPS - 1);
    assign o_stat.last_term = r_i == r_fill - 1'b1;
    assign o_stat.last_bin  = FW'(r_k) == w_lim;
    assign o_stat.out_busy  = r_o_valid;

    // ---------------- ring memory ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_ring[w_wp_eff[AW-1:0]] <= i_sample;
        if (i_cmd.rd)     r_rd <= r_ring[r_idx[AW-1:0]];
    end

    // ---------------- control-side state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl       <= sdb_pkg::RST_WINDOW_LENGTH;
            r_mf       <= sdb_pkg::RST_MIN_FILL;
            r_mb       <= sdb_pkg::RST_MAX_BIN;
            r_wp       <= '0;
            r_fill     <= '0;
            r_best_bin <= '0;
            r_last_bin <= '0;
            r_best_pow <= '0;
            r_total    <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cmd.cfg_wr) begin
                case (i_cfg_index)
                    sdb_pkg::CFG_WINDOW_LENGTH: r_wl <= i_cfg_data;
                    sdb_pkg::CFG_MIN_FILL:      r_mf <= i_cfg_data;
                    sdb_pkg::CFG_MAX_BIN:       r_mb <= i_cfg_data[BW-1:0];
                    default: ;
                endcase
                if (i_cfg_index == sdb_pkg::CFG_WINDOW_LENGTH ||
                    i_cfg_index == sdb_pkg::CFG_MIN_FILL ||
                    i_cfg_index == sdb_pkg::CFG_MAX_BIN) begin
                    r_wp       <= '0;
                    r_fill     <= '0;
                    r_best_bin <= '0;
                    r_last_bin <= '0;
                    r_best_pow <= '0;
                end
            end
            if (i_cmd.accept) begin
                r_total <= r_total + 1'b1;
                r_wp    <= w_wp_inc;
                if (w_fill < w_win) r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.cmp && o_stat.last_bin) begin
                r_best_bin <= w_nk;
                r_best_pow <= w_np;
            end
            if (i_cmd.load_out) begin
                r_o_valid <= 1'b1;
                if (o_stat.ran) r_last_bin <= r_best_bin;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // ---------------- sweep datapath ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.bin_init) begin
            r_k     <= BW'(1);
            r_found <= 1'b0;
            r_win_k <= '0;
            r_win_p <= '0;
        end
        if (i_cmd.term_init) begin
            r_i   <= '0;
            r_ph  <= 9'(r_k);
            r_acc <= '0;
            r_idx <= (r_wp >= w_fill) ? r_wp - w_fill : r_wp + w_win - w_fill;
        end
        if (i_cmd.rd) begin
            r_rem  <= {1'b0, r_ph};
            r_q    <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 1'b1;
            if (w_dtry >= {1'b0, w_div}) begin
                r_rem <= w_dtry - {1'b0, w_div};
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= w_dtry;
                r_q   <= {r_q[30:0], 1'b0};
            end
        end
        if (i_cmd.cor_init) begin
            r_x    <= sdb_pkg::CORDIC_INV_GAIN;
            r_y    <= '0;
            r_ccnt <= '0;
            // fold into the right half-plane when the angle lies in the left one
            if (((r_q + 32'h4000_0000) & 32'h8000_0000) != 32'd0) begin
                r_neg <= 1'b1;
                r_z   <= {{2{w_turn_fold[31]}}, w_turn_fold};
            end else begin
                r_neg <= 1'b0;
                r_z   <= {{2{r_q[31]}}, r_q};
            end
        end
        if (i_cmd.cor_step) begin
            r_ccnt <= r_ccnt + 1'b1;
            if (!r_z[XW-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end
        end
        if (i_cmd.mul) r_prod <= w_ma * w_mb;
        if (i_cmd.acc) begin
            r_acc <= r_acc + {{7{r_prod[33]}}, r_prod};
            r_i   <= r_i + 1'b1;
            r_ph  <= w_ph_sum[8:0];
            r_idx <= (r_idx + 1'b1 == w_win) ? '0 : r_idx + 1'b1;
        end
        if (i_cmd.rnd) r_coef <= w_ar[40:15];
        if (i_cmd.sq)  r_pow  <= w_sq[sdb_pkg::POWER_W-1:0];
        if (i_cmd.cmp) begin
            r_found <= 1'b1;
            r_win_k <= w_nk;
            r_win_p <= w_np;
            r_k     <= r_k + 1'b1;
        end
        if (i_cmd.load_out) begin
            o_analysed      <= o_stat.ran;
            o_dominant_bin  <= r_best_bin;
            o_peak_power    <= r_best_pow;
            o_window_fill   <= r_fill;
            o_bin_changed   <= o_stat.ran && (r_best_bin != r_last_bin);
            o_previous_bin  <= r_last_bin;
            o_total_samples <= r_total;
        end
    end

    assign o_valid = r_o_valid;

endmodule

// ===== design/sliding_dct_dominant_bin.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sliding_dct_dominant_bin
// Sliding-window DCT-II tracker reporting the strongest bin per sample.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// input     in         i_valid / o_ready          i_sample
// result    out        o_valid / i_ready          o_analysed .. o_total_samples
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One transaction at a time. An item that does not analyse skips the bin
// sweep. An analysed item with fill N sweeps K bins over N terms each:
// each term is a ring read, a restoring divider for the
// phase, 24 CORDIC rotations and a multiply-accumulate. The shared divider and
// CORDIC dominate the sweep. The result sits in an output register, so a new
// input transaction is taken while it waits. Synchronous active-low reset;
// the ring needs no clearing since only written entries are ever read.
// ---------------------------------------------------------------------------
module sliding_dct_dominant_bin #(
    parameter int MAX_WINDOW = 64,
    parameter int K_MAX      = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [sdb_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_analysed,
    output logic [sdb_pkg::BIN_W-1:0]            o_dominant_bin,
    output logic [sdb_pkg::POWER_W-1:0]          o_peak_power,
    output logic [sdb_pkg::FILL_W-1:0]           o_window_fill,
    output logic                                 o_bin_changed,
    output logic [sdb_pkg::BIN_W-1:0]            o_previous_bin,
    output logic [sdb_pkg::TOTAL_W-1:0]          o_total_samples,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [sdb_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [sdb_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    sdb_pkg::t_cmd  w_cmd;
    sdb_pkg::t_stat w_stat;

    // sequencer: config has priority over a sample in the same cycle
    sdb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_ready     (i_ready),
        .i_stat      (w_stat),
        .o_ready     (o_ready),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    sdb_dp #(
        .MAX_WINDOW (MAX_WINDOW),
        .K_MAX      (K_MAX)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_ready         (i_ready),
        .i_sample        (i_sample),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_analysed      (o_analysed),
        .o_dominant_bin  (o_dominant_bin),
        .o_peak_power    (o_peak_power),
        .o_window_fill   (o_window_fill),
        .o_bin_changed   (o_bin_changed),
        .o_previous_bin  (o_previous_bin),
        .o_total_samples (o_total_samples)
    );

endmodule

// ===== design/sdb_chk.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdb_chk
// Port-level checks for the dominant-bin tracker.
// ---------------------------------------------------------------------------
module sdb_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_analysed,
    input logic [sdb_pkg::BIN_W-1:0]   o_dominant_bin,
    input logic                        o_bin_changed,
    input logic [sdb_pkg::BIN_W-1:0]   o_previous_bin
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_dominant_bin))
        else $error("result changed while stalled");

    a_change_needs_analysis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_analysed |-> !o_bin_changed)
        else $error("bin change flagged without analysis");

    a_change_differs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bin_changed |-> o_dominant_bin != o_previous_bin)
        else $error("bin change flagged with equal bins");

    a_same_when_unchanged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_bin_changed |-> o_dominant_bin == o_previous_bin)
        else $error("bin moved without change flag");

endmodule

bind sliding_dct_dominant_bin sdb_chk u_sdb_chk (.*);

// ===== test/sliding_dct_dominant_bin_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sliding_dct_dominant_bin_tb
// Self-checking bench for the sliding DCT dominant-bin tracker: a clocked
// driver and monitor around u_top, a bit-exact CORDIC/DCT predictor, and
// phases of register settings with directed and random sample streams.
// ---------------------------------------------------------------------------
module sliding_dct_dominant_bin_tb;

    localparam int  MAXW      = 64;
    localparam int  KMAX      = 32;
    localparam int  LIMIT     = 12_000_000;  // watchdog limit, in cycles
    localparam int  HOLD_LEN  = 300;         // long receiver hold-off
    localparam longint INV_GAIN = 652032874;

    typedef struct {
        logic                          analysed;
        logic [sdb_pkg::BIN_W-1:0]     bin;
        logic [sdb_pkg::POWER_W-1:0]   power;
        logic [sdb_pkg::FILL_W-1:0]    fill;
        logic                          changed;
        logic [sdb_pkg::BIN_W-1:0]     prev;
        logic [sdb_pkg::TOTAL_W-1:0]   total;
    } t_bin_report;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic signed [sdb_pkg::SAMPLE_W-1:0] i_sample = '0;
    logic i_ready = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [sdb_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [sdb_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic o_ready, o_valid, o_analysed, o_bin_changed, o_cfg_ready;
    logic [sdb_pkg::BIN_W-1:0] o_dominant_bin, o_previous_bin;
    logic [sdb_pkg::POWER_W-1:0] o_peak_power;
    logic [sdb_pkg::FILL_W-1:0] o_window_fill;
    logic [sdb_pkg::TOTAL_W-1:0] o_total_samples;

    sliding_dct_dominant_bin u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // -------------------------------------------------------------------
    // Predictor state: own copy of the ring, pointers and registers
    // -------------------------------------------------------------------
    logic signed [sdb_pkg::SAMPLE_W-1:0] ring_q[MAXW];
    int unsigned wr_ptr, fill_n, peak_bin, shown_bin, total_n;
    longint unsigned peak_pwr;
    int unsigned reg_win, reg_need, reg_bins;

    logic signed [sdb_pkg::SAMPLE_W-1:0] pending_samples[$];
    t_bin_report                         expected_reports[$];
    int  errors;
    int  sent_items;
    bit  quiet;       // no idling in the final stretch
    bit  long_hold;   // ask the receiver for one long hold-off

    function automatic void clear_history();
        foreach (ring_q[i]) ring_q[i] = '0;
        wr_ptr = 0; fill_n = 0; peak_bin = 0; shown_bin = 0; peak_pwr = 0;
    endfunction

    // floor((v + 2^14) / 2^15)
    function automatic longint drop15(input longint v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    // Q1.15 cosine of an angle in binary turns, 24-step rotation CORDIC
    function automatic longint cordic_cos(input logic [31:0] turn);
        bit     neg;
        longint x, y, z, dx, dy, c;
        neg = 1'b0;
        x = INV_GAIN;
        y = 0;
        if (((turn + 32'h4000_0000) & 32'h8000_0000) != 0) begin
            turn = turn + 32'h8000_0000;
            neg = 1'b1;
        end
        z = longint'(signed'(turn));
        for (int s = 0; s < sdb_pkg::CORDIC_STEPS; s++) begin
            dx = y >>> s;
            dy = x >>> s;
            if (z >= 0) begin
                x -= dx; y += dy;
                z -= longint'(sdb_pkg::atan_turn(s[sdb_pkg::CNT_W-1:0]));
            end else begin
                x += dx; y -= dy;
                z += longint'(sdb_pkg::atan_turn(s[sdb_pkg::CNT_W-1:0]));
            end
        end
        c = drop15(x);
        if (neg) c = -c;
        if (c > 32768) c = 32768;
        if (c < -32768) c = -32768;
        return c;
    endfunction

    // Strongest DCT-II bin over the held samples, oldest first
    function automatic void sweep_bins(input int unsigned w);
        longint    xs[MAXW];
        longint    acc, coef;
        longint unsigned pw, win_p, ph;
        logic [31:0] turn;
        int unsigned lim, win_k;
        bit found;
        lim = reg_bins;
        if (lim > KMAX) lim = KMAX;
        if (lim > fill_n / 2) lim = fill_n / 2;
        if (lim < 1 || fill_n == 0 || fill_n > w) return;
        for (int unsigned i = 0; i < fill_n; i++)
            xs[i] = ring_q[(wr_ptr + 2 * w - fill_n + i) % w];
        found = 0; win_p = 0; win_k = 0;
        for (int unsigned k = 1; k <= lim; k++) begin
            acc = 0;
            for (int unsigned i = 0; i < fill_n; i++) begin
                ph = (longint'(2 * i + 1) * k) % (4 * fill_n);
                turn = 32'((ph << 32) / (4 * fill_n));
                acc += xs[i] * cordic_cos(turn);
            end
            coef = drop15(acc);
            pw = longint'(coef * coef);
            if (!found || pw > win_p) begin
                found = 1; win_p = pw; win_k = k;
            end
        end
        peak_bin = win_k;
        peak_pwr = win_p & 64'h7FF_FFFF_FFFF;
    endfunction

    function automatic t_bin_report track_sample(
        input logic signed [sdb_pkg::SAMPLE_W-1:0] s);
        t_bin_report r;
        int unsigned w, need;
        w = reg_win < sdb_pkg::MIN_WIN ? sdb_pkg::MIN_WIN :
            (reg_win > MAXW ? MAXW : reg_win);
        need = reg_need < sdb_pkg::MIN_NEED ? sdb_pkg::MIN_NEED : reg_need;
        r.prev = shown_bin[sdb_pkg::BIN_W-1:0];
        r.analysed = 1'b0;
        r.changed = 1'b0;
        total_n++;
        if (wr_ptr >= w) wr_ptr = 0;
        ring_q[wr_ptr] = s;
        wr_ptr = (wr_ptr + 1) % w;
        if (fill_n < w) fill_n++;
        if (fill_n >= need) begin
            r.analysed = 1'b1;
            sweep_bins(w);
            if (peak_bin != shown_bin) begin
                r.changed = 1'b1;
                shown_bin = peak_bin;
            end
        end
        r.bin = peak_bin[sdb_pkg::BIN_W-1:0];
        r.power = peak_pwr[sdb_pkg::POWER_W-1:0];
        r.fill = fill_n[sdb_pkg::FILL_W-1:0];
        r.total = total_n;
        return r;
    endfunction

    // -------------------------------------------------------------------
    // Sample driver: valid/ready with random idle bursts
    // -------------------------------------------------------------------
    bit in_taken = 1'b0;
    int in_gap = 0;

    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready)
            expected_reports.push_back(track_sample(i_sample));
    end

    always @(negedge i_clk) begin
        logic nxt_valid;
        logic signed [sdb_pkg::SAMPLE_W-1:0] nxt_sample;
        nxt_valid = i_valid;
        nxt_sample = i_sample;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!i_valid || in_taken) begin
            nxt_valid = 1'b0;
            if (in_gap > 0 && !quiet) begin
                in_gap--;
            end else if (pending_samples.size() > 0) begin
                nxt_sample = pending_samples.pop_front();
                nxt_valid = 1'b1;
                sent_items++;
                if (!quiet && $urandom_range(0, 5) == 0)
                    in_gap = $urandom_range(1, 9);
            end
        end
        i_valid <= nxt_valid;
        i_sample <= nxt_sample;
    end

    // -------------------------------------------------------------------
    // Result monitor and receiver stalls
    // -------------------------------------------------------------------
    int out_gap = 0;
    int hold_cnt = 0;

    always @(negedge i_clk) begin
        logic nxt_ready;
        nxt_ready = 1'b1;
        if (!i_rst_n) begin
            nxt_ready = 1'b0;
        end else if (long_hold && hold_cnt < HOLD_LEN) begin
            hold_cnt++;
            nxt_ready = 1'b0;
        end else if (out_gap > 0 && !quiet) begin
            out_gap--;
            nxt_ready = 1'b0;
        end else if (!quiet && $urandom_range(0, 6) == 0) begin
            out_gap = $urandom_range(0, 8);
            nxt_ready = 1'b0;
        end
        i_ready <= nxt_ready;
    end

    always @(posedge i_clk) begin
        t_bin_report e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected result transaction, bin %0d", $time, o_dominant_bin);
                errors++;
            end else begin
                e = expected_reports.pop_front();
                if (o_analysed !== e.analysed) begin
                    $display("%0t: analysed exp %0d got %0d", $time, e.analysed, o_analysed);
                    errors++;
                end
                if (o_dominant_bin !== e.bin) begin
                    $display("%0t: dominant_bin exp %0d got %0d", $time, e.bin, o_dominant_bin);
                    errors++;
                end
                if (o_peak_power !== e.power) begin
                    $display("%0t: peak_power exp %0d got %0d", $time, e.power, o_peak_power);
                    errors++;
                end
                if (o_window_fill !== e.fill) begin
                    $display("%0t: window_fill exp %0d got %0d", $time, e.fill, o_window_fill);
                    errors++;
                end
                if (o_bin_changed !== e.changed) begin
                    $display("%0t: bin_changed exp %0d got %0d", $time, e.changed,
                             o_bin_changed);
                    errors++;
                end
                if (o_previous_bin !== e.prev) begin
                    $display("%0t: previous_bin exp %0d got %0d", $time, e.prev,
                             o_previous_bin);
                    errors++;
                end
                if (o_total_samples !== e.total) begin
                    $display("%0t: total_samples exp %0d got %0d", $time, e.total,
                             o_total_samples);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    int cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // -------------------------------------------------------------------
    // Stimulus
    // -------------------------------------------------------------------
    // Block is idle once nothing is queued, offered or owed.
    task automatic drain();
        while (pending_samples.size() != 0 || i_valid || expected_reports.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [sdb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sdb_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            sdb_pkg::CFG_WINDOW_LENGTH: begin reg_win = data; clear_history(); end
            sdb_pkg::CFG_MIN_FILL:      begin reg_need = data; clear_history(); end
            sdb_pkg::CFG_MAX_BIN:       begin reg_bins = data & 7'h3F; clear_history(); end
            default: ;         // unlisted index: no effect
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input int w, input int mf, input int mb);
        write_reg(sdb_pkg::CFG_WINDOW_LENGTH, w[sdb_pkg::CFG_DATA_W-1:0]);
        write_reg(sdb_pkg::CFG_MIN_FILL, mf[sdb_pkg::CFG_DATA_W-1:0]);
        write_reg(sdb_pkg::CFG_MAX_BIN, mb[sdb_pkg::CFG_DATA_W-1:0]);
    endtask

    function automatic logic signed [sdb_pkg::SAMPLE_W-1:0] pick_sample(input int style,
                                                                       input int j);
        case (style)
            0: return 16'($urandom);
            1: begin
                case ($urandom_range(0, 4))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    3: return 16'shFFFF;
                    default: return 16'sh0001;
                endcase
            end
            // square wave whose half-period is style, plus noise: a clear peak bin
            default: return ((j / style) % 2 ? 16'sh6000 : -16'sh6000) +
                            $signed(16'($urandom_range(0, 2047))) - 16'sh0400;
        endcase
    endfunction

    task automatic feed(input int count, input int style);
        for (int j = 0; j < count; j++)
            pending_samples.push_back(pick_sample(style, j));
    endtask

    initial begin
        int w, mf, mb, n;
        errors = 0; sent_items = 0; quiet = 0; long_hold = 0; total_n = 0;
        reg_win = sdb_pkg::RST_WINDOW_LENGTH;
        reg_need = sdb_pkg::RST_MIN_FILL;
        reg_bins = sdb_pkg::RST_MAX_BIN;
        clear_history();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: extremes, analysis starts at the 16th sample
        pending_samples.push_back(16'sh7FFF);
        pending_samples.push_back(16'sh8000);
        feed(15, 1);
        drain();

        // Window and min fill below their floors, max_bin above K_MAX
        set_regs(0, 0, 63);
        feed(4, 1);
        drain();
        // unlisted index leaves the history alone
        write_reg(2'd3, 7'h7F);
        feed(4, 3);
        drain();

        // Window register above MAX_WINDOW, min fill never reached
        set_regs(127, 127, 5);
        feed(6, 0);
        drain();

        // No bins to examine: analysed but best bin kept
        set_regs(8, 4, 0);
        feed(6, 0);
        drain();

        // Full window: a long receiver hold-off stalls the first results
        set_regs(64, 64, 32);
        long_hold = 1;
        feed(65, 4);
        drain();

        // Random settings, small windows keep the sweep short
        while (sent_items < 270) begin
            w = $urandom_range(8, 14);
            if ($urandom_range(0, 3) == 0) w = $urandom_range(0, 127);
            if (w > 14 || w < 8) mf = $urandom_range(60, 127);
            else mf = $urandom_range(0, w + 3);
            mb = $urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(1, 7);
            n = $urandom_range(10, 28);
            set_regs(w, mf, mb);
            feed(n, $urandom_range(0, 6));
            drain();
        end

        // Final stretch without idling
        quiet = 1;
        set_regs(12, 4, 6);
        feed(20, 0);
        drain();
        repeat (50) @(posedge i_clk);

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
